// File: rtl/pat_pkg.sv
// ----------------------------------------------------------------------------
// Pending acknowledgement table package
// Shared entry type, cell control type and the action and status codes.
// ----------------------------------------------------------------------------
package pat_pkg;

  typedef enum logic [1:0] {
    ACT_ADD  = 2'd0,
    ACT_ACK  = 2'd1,
    ACT_TICK = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_ACK_OK    = 3'd2,
    ST_ACK_FAIL  = 3'd3,
    ST_NO_MATCH  = 3'd4,
    ST_TIMED_OUT = 3'd5
  } status_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] contact;
    logic [31:0] msg_id;
    logic [31:0] event_tag;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  localparam logic [31:0] TIMEOUT_RESET = 32'd65000;

endpackage

// File: rtl/pat_cell.sv
// ----------------------------------------------------------------------------
// Pending acknowledgement table cell
// Holds one table entry. It loads the insert bus, takes its right-hand
// neighbour's entry or holds, as the controller directs.
// ----------------------------------------------------------------------------
module pat_cell
  import pat_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  entry_t    ins_i,
  input  entry_t    nbr_i,
  output entry_t    ent_o
);

  entry_t ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else if (ctl.load) begin
      ent_r <= ins_i;
    end else if (ctl.shift) begin
      ent_r <= nbr_i;
    end
  end

  assign ent_o = ent_r;

endmodule

// File: rtl/pending_ack_timeout_table.sv
// An add is accepted in the idle state and gives its result from the finish
// state; an ack or a tick first rotates the table once through the cell chain
// past the head cell, entry by entry, before it finishes.
// One transaction at a time: the input stalls while a transaction is in
// progress; a stalled result holds the sweep and the input.
// Reset clears all valid marks and control state and loads the timeout with 65000.
// ----------------------------------------------------------------------------
// Pending acknowledgement timeout table
// Ordered table of outstanding sends built as a chain of entry cells. Acks
// and ticks rotate the valid part of the chain through the head cell,
// dropping matched or expired entries while keeping the order of the rest.
// ----------------------------------------------------------------------------
module pending_ack_timeout_table
  import pat_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_contact,
  input  logic [31:0] in_msg_id,
  input  logic [31:0] in_event_tag,
  input  logic        in_success,
  input  logic [31:0] in_now,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_contact_out,
  output logic [31:0] out_msg_id_out,
  output logic [31:0] out_event_tag_out,
  output logic        out_last
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIN
  } state_t;

  state_t        state_r, state_nxt;
  logic [31:0]   timeout_r;
  logic [1:0]    act_r, act_nxt;
  logic [31:0]   req_contact_r, req_contact_nxt;
  logic [31:0]   req_msg_r, req_msg_nxt;
  logic [31:0]   req_event_r, req_event_nxt;
  logic          req_success_r, req_success_nxt;
  logic [31:0]   req_now_r, req_now_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          hold_v_r, hold_v_nxt;
  logic [31:0]   hold_contact_r, hold_contact_nxt;
  logic [31:0]   hold_msg_r, hold_msg_nxt;
  logic [31:0]   hold_event_r, hold_event_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_status_r, out_status_nxt;
  logic [31:0]   out_contact_r, out_contact_nxt;
  logic [31:0]   out_msg_r, out_msg_nxt;
  logic [31:0]   out_event_r, out_event_nxt;
  logic          out_last_r, out_last_nxt;

  entry_t                 ent [TABLE_DEPTH];
  entry_t                 ins;
  entry_t                 head;
  logic [TABLE_DEPTH-1:0] load_v;
  logic [TABLE_DEPTH-1:0] shift_v;
  logic [31:0]            age;
  logic                   expired;
  logic                   match;
  logic                   drop;
  logic                   out_ready;
  logic                   in_acc;

  assign head      = ent[0];
  assign age       = req_now_r - head.stamp;
  assign expired   = age > timeout_r;
  assign match     = (head.contact == req_contact_r) && (head.msg_id == req_msg_r);
  assign out_ready = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign drop      = (act_r == ACT_ACK) ? (match && !hold_v_r) : expired;

  always_comb begin
    state_nxt        = state_r;
    act_nxt          = act_r;
    req_contact_nxt  = req_contact_r;
    req_msg_nxt      = req_msg_r;
    req_event_nxt    = req_event_r;
    req_success_nxt  = req_success_r;
    req_now_nxt      = req_now_r;
    fill_nxt         = fill_r;
    cnt_nxt          = cnt_r;
    hold_v_nxt       = hold_v_r;
    hold_contact_nxt = hold_contact_r;
    hold_msg_nxt     = hold_msg_r;
    hold_event_nxt   = hold_event_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_status_nxt   = out_status_r;
    out_contact_nxt  = out_contact_r;
    out_msg_nxt      = out_msg_r;
    out_event_nxt    = out_event_r;
    out_last_nxt     = out_last_r;
    load_v           = '0;
    shift_v          = '0;
    ins              = head;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          act_nxt         = in_action;
          req_contact_nxt = in_contact;
          req_msg_nxt     = in_msg_id;
          req_event_nxt   = in_event_tag;
          req_success_nxt = in_success;
          req_now_nxt     = in_now;
          hold_v_nxt      = 1'b0;
          cnt_nxt         = fill_r;
          unique case (in_action)
            ACT_ADD: state_nxt = S_FIN;
            ACT_ACK, ACT_TICK: state_nxt = (fill_r == '0) ? S_FIN : S_RUN;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_RUN: begin
        if (out_ready) begin
          ins.valid = !drop;
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            shift_v[i] = (CW'(i + 1) < fill_r);
            load_v[i]  = (CW'(i + 1) == fill_r);
          end
          if (drop) begin
            fill_nxt         = fill_r - CW'(1);
            hold_v_nxt       = 1'b1;
            hold_contact_nxt = head.contact;
            hold_msg_nxt     = head.msg_id;
            hold_event_nxt   = head.event_tag;
            if (act_r == ACT_TICK && hold_v_r) begin
              out_valid_nxt   = 1'b1;
              out_status_nxt  = ST_TIMED_OUT;
              out_contact_nxt = hold_contact_r;
              out_msg_nxt     = hold_msg_r;
              out_event_nxt   = hold_event_r;
              out_last_nxt    = 1'b0;
            end
          end
          cnt_nxt = cnt_r - CW'(1);
          if (cnt_r == CW'(1)) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (out_ready) begin
          state_nxt    = S_IDLE;
          out_last_nxt = 1'b1;
          unique case (act_r)
            ACT_ADD: begin
              out_valid_nxt   = 1'b1;
              out_contact_nxt = req_contact_r;
              out_msg_nxt     = req_msg_r;
              out_event_nxt   = req_event_r;
              if (fill_r == CW'(TABLE_DEPTH)) begin
                out_status_nxt = ST_FULL;
              end else begin
                out_status_nxt = ST_ADDED;
                ins.valid      = 1'b1;
                ins.contact    = req_contact_r;
                ins.msg_id     = req_msg_r;
                ins.event_tag  = req_event_r;
                ins.stamp      = req_now_r;
                fill_nxt       = fill_r + CW'(1);
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                  load_v[i] = (CW'(i) == fill_r);
                end
              end
            end
            ACT_ACK: begin
              out_valid_nxt = 1'b1;
              if (hold_v_r) begin
                out_status_nxt  = req_success_r ? ST_ACK_OK : ST_ACK_FAIL;
                out_contact_nxt = hold_contact_r;
                out_msg_nxt     = hold_msg_r;
                out_event_nxt   = hold_event_r;
              end else begin
                out_status_nxt  = ST_NO_MATCH;
                out_contact_nxt = req_contact_r;
                out_msg_nxt     = req_msg_r;
                out_event_nxt   = '0;
              end
            end
            ACT_TICK: begin
              if (hold_v_r) begin
                out_valid_nxt   = 1'b1;
                out_status_nxt  = ST_TIMED_OUT;
                out_contact_nxt = hold_contact_r;
                out_msg_nxt     = hold_msg_r;
                out_event_nxt   = hold_event_r;
              end
            end
            default: begin
              out_last_nxt = out_last_r;
            end
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      timeout_r   <= TIMEOUT_RESET;
      fill_r      <= '0;
      cnt_r       <= '0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
    end
    act_r          <= act_nxt;
    req_contact_r  <= req_contact_nxt;
    req_msg_r      <= req_msg_nxt;
    req_event_r    <= req_event_nxt;
    req_success_r  <= req_success_nxt;
    req_now_r      <= req_now_nxt;
    hold_contact_r <= hold_contact_nxt;
    hold_msg_r     <= hold_msg_nxt;
    hold_event_r   <= hold_event_nxt;
    out_status_r   <= out_status_nxt;
    out_contact_r  <= out_contact_nxt;
    out_msg_r      <= out_msg_nxt;
    out_event_r    <= out_event_nxt;
    out_last_r     <= out_last_nxt;
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    cell_ctl_t ctl;
    entry_t    nbr;

    assign ctl = '{load: load_v[g], shift: shift_v[g]};

    if (g == TABLE_DEPTH - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = ent[g + 1];
    end

    pat_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .ins_i (ins),
      .nbr_i (nbr),
      .ent_o (ent[g])
    );
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_contact_out   = out_contact_r;
  assign out_msg_id_out    = out_msg_r;
  assign out_event_tag_out = out_event_r;
  assign out_last          = out_last_r;

endmodule

// File: rtl/pat_checker.sv
// ----------------------------------------------------------------------------
// Pending acknowledgement table checker
// Port-level assertions on the table's transactions, bound to the top level.
// ----------------------------------------------------------------------------
module pat_checker
  import pat_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [31:0] out_contact_out,
  input logic [31:0] out_msg_id_out,
  input logic [31:0] out_event_tag_out,
  input logic        out_last
);

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !in_stall && !out_valid)
    else $error("table not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_contact_out) && $stable(out_msg_id_out)
      && $stable(out_event_tag_out) && $stable(out_last))
    else $error("stalled result transaction changed");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_ADDED || out_status == ST_FULL
      || out_status == ST_ACK_OK || out_status == ST_ACK_FAIL
      || out_status == ST_NO_MATCH) |-> out_last)
    else $error("single result transaction without last");

  a_no_match_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NO_MATCH |-> out_event_tag_out == 32'd0)
    else $error("no-match result carries an event tag");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_TIMED_OUT)
    else $error("result status out of range");

endmodule

bind pending_ack_timeout_table pat_checker u_pat_checker (.*);
